// ----- src/one_wire_bus_timing_master_assert.svh -----
// Assertion macros used by the one-wire bus master RTL.
// Needs a clock named clk and an active-low synchronous reset named rst_n in scope.
`ifndef ONE_WIRE_BUS_TIMING_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_TIMING_MASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OWBM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("owbm assertion failed (same cycle)");

// Next-cycle implication, checked outside reset.
`define OWBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("owbm assertion failed (next cycle)");

`endif

// ----- src/owbm_pkg.sv -----
// Package for the one-wire bus master: payload structs, command and phase codes,
// timing register indexes and reset values. Depends on nothing.
package owbm_pkg;

  localparam int REG_W     = 10;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int PHASE_W   = 4;

  // Command codes.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_RESET      = 3'd1;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd2;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd3;
  localparam logic [2:0] CMD_WRITE_BIT  = 3'd4;
  localparam logic [2:0] CMD_READ_BIT   = 3'd5;

  // Sequencer phases.
  localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_W-1:0] PH_RST_LOW = 4'd1;
  localparam logic [PHASE_W-1:0] PH_RST_S1  = 4'd2;
  localparam logic [PHASE_W-1:0] PH_RST_S2  = 4'd3;
  localparam logic [PHASE_W-1:0] PH_WR_LOW  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WR_SLOT = 4'd5;
  localparam logic [PHASE_W-1:0] PH_WR_GAP  = 4'd6;
  localparam logic [PHASE_W-1:0] PH_RD_LOW  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_RD_WAIT = 4'd8;
  localparam logic [PHASE_W-1:0] PH_RD_REC  = 4'd9;

  // Timing register indexes.
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_REC   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_LOW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_SLOT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BYTE_GAP    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE = 3'd7;

  localparam logic [REG_W-1:0] REG_RESET_VAL [NUM_REGS] =
    '{10'd500, 10'd30, 10'd470, 10'd5, 10'd80, 10'd100, 10'd2, 10'd15};

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       bus_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_value;
    logic       rejected;
  } owbm_out_t;

endpackage

// ----- src/one_wire_bus_timing_master.sv -----
// Top level of the one-wire bus timing master: phase sequencer, result register.
// Depends on owbm_pkg, owbm_regs and one_wire_bus_timing_master_assert.svh.
//
//   Channel  Ports                              Direction  Transfer when
//   input    in_valid, in_ready, in_data        into       in_valid & in_ready
//   result   out_valid, out_ready, out_data     out of     out_valid & out_ready
//   config   cfg_we, cfg_index, cfg_wdata       into       cfg_we
//
// Every input transfer produces exactly one result in the result register; the
// block takes one item per cycle while the single result register is free or being taken.
// A stalled result holds the input side only while out_ready is low and the
// result register is full; otherwise a new item is accepted in the same cycle
// the old result leaves. Reset is synchronous and active low; it clears the
// sequencer and the result valid flag and restores the timing defaults.
module one_wire_bus_timing_master #(
  parameter int COUNT_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  owbm_pkg::owbm_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output owbm_pkg::owbm_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [owbm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [owbm_pkg::REG_W-1:0]     cfg_wdata
);
  import owbm_pkg::*;

  `include "one_wire_bus_timing_master_assert.svh"

  // Sequencer state.
  logic [PHASE_W-1:0]    phase_r,     phase_nxt;
  logic [COUNT_BITS-1:0] tick_r,      tick_nxt;
  logic [2:0]            bit_idx_r,   bit_idx_nxt;
  logic [7:0]            shift_r,     shift_nxt;
  logic                  pres_r,      pres_nxt;
  logic                  drive_r,     drive_nxt;
  logic                  byte_mode_r, byte_mode_nxt;

  // Result register.
  logic                  out_valid_r, out_valid_nxt;
  owbm_out_t             out_r,       out_nxt;

  logic [COUNT_BITS-1:0] phase_len;
  logic                  gap_en;
  logic                  accept;

  owbm_regs #(
    .COUNT_BITS (COUNT_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .phase     (phase_r),
    .phase_len (phase_len),
    .gap_en    (gap_en)
  );

  // The result register frees up in the same cycle its content is taken.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  done;
    logic                  rej;
    logic [7:0]            rval;
    logic                  cur_bit;

    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    pres_nxt      = pres_r;
    drive_nxt     = drive_r;
    byte_mode_nxt = byte_mode_r;
    done          = 1'b0;
    rej           = 1'b0;
    rval          = '0;
    cur_bit       = shift_r[bit_idx_r];
    // The tick counter saturates at its top value.
    cnt_inc       = (tick_r != {COUNT_BITS{1'b1}}) ? tick_r + 1'b1 : tick_r;

    if (in_data.cmd != CMD_TICK) begin
      // Unknown command codes fall through every arm and change nothing.
      if (phase_r != PH_IDLE) begin
        rej = (in_data.cmd == CMD_RESET) || (in_data.cmd == CMD_WRITE_BYTE) ||
              (in_data.cmd == CMD_READ_BYTE) || (in_data.cmd == CMD_WRITE_BIT) ||
              (in_data.cmd == CMD_READ_BIT);
      end else begin
        case (in_data.cmd)
          CMD_RESET: begin
            shift_nxt = '0;
            phase_nxt = PH_RST_LOW;
            tick_nxt  = '0;
            drive_nxt = 1'b1;
          end
          CMD_WRITE_BYTE, CMD_WRITE_BIT: begin
            byte_mode_nxt = (in_data.cmd == CMD_WRITE_BYTE);
            shift_nxt     = (in_data.cmd == CMD_WRITE_BYTE) ? in_data.data_byte
                                                            : {7'd0, in_data.data_byte[0]};
            bit_idx_nxt   = '0;
            phase_nxt     = PH_WR_LOW;
            tick_nxt      = '0;
            drive_nxt     = 1'b1;
          end
          CMD_READ_BYTE, CMD_READ_BIT: begin
            byte_mode_nxt = (in_data.cmd == CMD_READ_BYTE);
            shift_nxt     = '0;
            bit_idx_nxt   = '0;
            phase_nxt     = PH_RD_LOW;
            tick_nxt      = '0;
            drive_nxt     = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else if (phase_r != PH_IDLE) begin
      tick_nxt = cnt_inc;
      if (cnt_inc >= phase_len) begin
        // Every transition restarts the count; drive defaults to released.
        tick_nxt  = '0;
        drive_nxt = 1'b0;
        case (phase_r)
          PH_RST_LOW: begin
            phase_nxt = PH_RST_S1;
          end
          PH_RST_S1: begin
            // First presence sample: a device answers by holding the line low.
            shift_nxt = {7'd0, !in_data.bus_level};
            phase_nxt = PH_RST_S2;
          end
          PH_RST_S2: begin
            // Second sample: the line must be back high.
            pres_nxt  = shift_r[0] && in_data.bus_level;
            shift_nxt = '0;
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_WR_LOW: begin
            // A zero bit keeps the line low through the whole slot.
            phase_nxt = PH_WR_SLOT;
            drive_nxt = !cur_bit;
          end
          PH_WR_SLOT: begin
            if (byte_mode_r && (bit_idx_r != 3'd7)) begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              phase_nxt   = PH_WR_LOW;
              drive_nxt   = 1'b1;
            end else if (byte_mode_r && gap_en) begin
              phase_nxt = PH_WR_GAP;
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end
          end
          PH_WR_GAP: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_RD_LOW: begin
            phase_nxt = PH_RD_WAIT;
          end
          PH_RD_WAIT: begin
            shift_nxt            = shift_r;
            shift_nxt[bit_idx_r] = shift_r[bit_idx_r] | in_data.bus_level;
            if (byte_mode_r) begin
              phase_nxt = PH_RD_REC;
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              rval      = {7'd0, shift_nxt[0]};
            end
          end
          default: begin
            // Read recovery: next bit or end of the byte.
            if (bit_idx_r != 3'd7) begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              phase_nxt   = PH_RD_LOW;
              drive_nxt   = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
              rval      = shift_r;
            end
          end
        endcase
      end
    end

    out_nxt.drive_low  = drive_nxt;
    out_nxt.busy_res   = (phase_nxt != PH_IDLE);
    out_nxt.done_res   = done;
    out_nxt.presence   = pres_nxt;
    out_nxt.read_value = rval;
    out_nxt.rejected   = rej;

    out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_ready);
  end

  // Control state: cleared by reset; out_valid_r aside, updated only on a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_idx_r   <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      drive_r     <= 1'b0;
      byte_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        bit_idx_r   <= bit_idx_nxt;
        shift_r     <= shift_nxt;
        pres_r      <= pres_nxt;
        drive_r     <= drive_nxt;
        byte_mode_r <= byte_mode_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  `OWBM_ASSERT_NOW(a_done_not_busy, out_valid_r && out_r.done_res, !out_r.busy_res)
  `OWBM_ASSERT_NOW(a_reject_busy, out_valid_r && out_r.rejected, out_r.busy_res)
  `OWBM_ASSERT_NOW(a_rval_on_done, out_valid_r && (out_r.read_value != '0), out_r.done_res)
  `OWBM_ASSERT_NOW(a_idle_released, phase_r == PH_IDLE, !drive_r)
  `OWBM_ASSERT_NEXT(a_stall_blocks, accept, out_valid_r)

endmodule

// ----- src/owbm_regs.sv -----
// Timing register file of the one-wire bus master, with length selection per phase
// and clipping to the tick counter range. Depends on owbm_pkg.
module owbm_regs #(
  parameter int COUNT_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [owbm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [owbm_pkg::REG_W-1:0]        cfg_wdata,
  input  logic [owbm_pkg::PHASE_W-1:0]      phase,
  output logic [COUNT_BITS-1:0]             phase_len,
  output logic                              gap_en
);
  import owbm_pkg::*;

  localparam int LW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  logic [REG_W-1:0]     regs_r [NUM_REGS];
  logic [REG_IDX_W-1:0] sel;
  logic [LW-1:0]        ext;
  logic [LW-1:0]        cnt_max;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= REG_RESET_VAL[i];
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    case (phase)
      PH_RST_LOW: sel = REG_RESET_LOW;
      PH_RST_S1:  sel = REG_PRES_SAMPLE;
      PH_RST_S2:  sel = REG_RESET_REC;
      PH_WR_LOW:  sel = REG_WRITE_LOW;
      PH_WR_SLOT: sel = REG_WRITE_SLOT;
      PH_WR_GAP:  sel = REG_BYTE_GAP;
      PH_RD_LOW:  sel = REG_READ_LOW;
      default:    sel = REG_READ_SAMPLE;
    endcase
  end

  // A length beyond the counter range is clipped to the counter's top value.
  assign cnt_max   = LW'({COUNT_BITS{1'b1}});
  assign ext       = LW'(regs_r[sel]);
  assign phase_len = (ext > cnt_max) ? COUNT_BITS'(cnt_max) : COUNT_BITS'(ext);
  assign gap_en    = (regs_r[REG_BYTE_GAP] != '0);

endmodule
